FILE: sv/erpv_pkg.sv
// Shared types and constants for the Euler rotation and projection block.
// No dependencies; the channel interfaces and the top level use this package.
package erpv_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [14:0] SIN_B = 15'd21024;
    localparam logic [11:0] SIN_C = 12'd2320;

    localparam int NEAR_Q88 = 25;
    localparam int FOCAL    = 100;
    localparam int QUO_BITS = 13;
    localparam int NUM_LANES = 6;

    localparam logic [1:0] CFG_CENTER_X  = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y  = 2'd1;
    localparam logic [1:0] CFG_VIEW_DIST = 2'd2;

    localparam logic [9:0]  CENTER_X_RST  = 10'd200;
    localparam logic [9:0]  CENTER_Y_RST  = 10'd165;
    localparam logic [14:0] VIEW_DIST_RST = 15'd20480;

    localparam logic signed [11:0] SCREEN_HI = 12'sd2047;
    localparam logic signed [11:0] SCREEN_LO = -12'sd2048;

    typedef struct packed {
        logic        [15:0] roll_angle;
        logic        [15:0] pitch_angle;
        logic        [15:0] yaw_angle;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } t_in_item;

    typedef struct packed {
        logic signed [11:0] screen_x;
        logic signed [11:0] screen_y;
        logic signed [15:0] rotated_z;
        logic               in_front;
    } t_out_item;

endpackage

FILE: sv/erpv_in_if.sv
// Valid/ready channel carrying one vertex item with its three angles.
// Depends on erpv_pkg for the item type.
interface erpv_in_if;
    logic              valid;
    logic              ready;
    erpv_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/erpv_out_if.sv
// Valid/ready channel carrying one projected screen item.
// Depends on erpv_pkg for the item type.
interface erpv_out_if;
    logic               valid;
    logic               ready;
    erpv_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/euler_rotate_and_project_vertex.sv
// Euler Z-Y-X rotation of one vertex followed by perspective projection.
// Depends on erpv_pkg, erpv_in_if and erpv_out_if.
//
// Usage:
//   i_vtx carries one item per handshake: roll, pitch, yaw and a Q8.8 vertex.
//   o_pix returns one item per input item, in order: screen x/y, rotated z
//   and the in-front flag.
//   Configuration (center x/y, view distance) is written through
//   i_cfg_we/i_cfg_idx/i_cfg_data, one register per cycle, while idle.
// Pipeline:
//   27-stage pipeline. One item per cycle is sustained while o_pix is
//   ready; the stages are the six sine polynomial lanes (5 stages), the
//   matrix and vertex products (4 stages), the projection numerator
//   (4 stages) and a restoring divider that resolves one quotient bit per
//   stage (13 stages), plus the output register.
// Reset clears all valid bits and loads the register defaults.
// When o_pix stalls, each stage holds; empty stages still fill, so i_vtx
// stays ready until the pipeline is full.
module euler_rotate_and_project_vertex #(
    parameter int ANGLE_BITS = erpv_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = erpv_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    erpv_in_if.sink     i_vtx,
    erpv_out_if.source  o_pix,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    localparam int MW = 18;
    localparam int PW = COORD_BITS + MW;
    localparam int SW = PW + 2;
    localparam int RB = COORD_BITS + 6;
    localparam int DW = RB + 1;
    localparam int NW = RB + 13;
    localparam int QB = erpv_pkg::QUO_BITS;
    localparam int NL = erpv_pkg::NUM_LANES;
    localparam int ST_DIV0 = 13;
    localparam int ST_OUT = ST_DIV0 + QB;
    localparam int NS = ST_OUT + 1;

    localparam logic signed [RB-1:0] Z_HI =
        {{(RB-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [RB-1:0] Z_LO =
        {{(RB-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    function automatic logic signed [16:0] qmul(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
        logic signed [33:0] p;
        p = 34'(a) * 34'(b) + 34'sd8192;
        return p[30:14];
    endfunction

    // configuration
    logic [9:0]  r_center_x;
    logic [9:0]  r_center_y;
    logic [14:0] r_view_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= erpv_pkg::CENTER_X_RST;
            r_center_y  <= erpv_pkg::CENTER_Y_RST;
            r_view_dist <= erpv_pkg::VIEW_DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                erpv_pkg::CFG_CENTER_X:  r_center_x  <= i_cfg_data[9:0];
                erpv_pkg::CFG_CENTER_Y:  r_center_y  <= i_cfg_data[9:0];
                erpv_pkg::CFG_VIEW_DIST: r_view_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and stage enables
    logic [NS-1:0] r_vld;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = o_pix.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_vtx.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vtx.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: quarter-wave positions; lanes are sr, cr, sp, cp, sy, cy
    logic [15:0]                   r0_x [NL];
    logic [NL-1:0]                 r0_neg;
    logic signed [COORD_BITS-1:0]  r0_v [3];
    logic [31:0]                   ang_ext [3];
    logic [31:0]                   crd_ext [3];
    logic [31:0]                   ph [NL];
    logic [15:0]                   n_x [NL];

    always_comb begin
        ang_ext[0] = {16'b0, i_vtx.data.roll_angle};
        ang_ext[1] = {16'b0, i_vtx.data.pitch_angle};
        ang_ext[2] = {16'b0, i_vtx.data.yaw_angle};
        crd_ext[0] = {16'b0, i_vtx.data.vertex_x};
        crd_ext[1] = {16'b0, i_vtx.data.vertex_y};
        crd_ext[2] = {16'b0, i_vtx.data.vertex_z};
        for (int l = 0; l < NL; l++) begin
            ph[l] = {ang_ext[l/2][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}}
                    + ((l % 2 == 1) ? 32'h4000_0000 : 32'h0);
            n_x[l] = ph[l][30] ? 16'(17'd32768 - {2'b0, ph[l][29:15]})
                               : {1'b0, ph[l][29:15]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int l = 0; l < NL; l++) begin
                r0_x[l]   <= n_x[l];
                r0_neg[l] <= ph[l][31];
            end
            for (int c = 0; c < 3; c++) begin
                r0_v[c] <= crd_ext[c][COORD_BITS-1:0];
            end
        end
    end

    // stage 1: x^2
    logic [15:0]                  r1_x [NL];
    logic [15:0]                  r1_x2 [NL];
    logic [NL-1:0]                r1_neg;
    logic signed [COORD_BITS-1:0] r1_v [3];
    logic [31:0]                  sq [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            sq[l] = r0_x[l] * r0_x[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int l = 0; l < NL; l++) begin
                r1_x[l]  <= r0_x[l];
                r1_x2[l] <= sq[l][30:15];
            end
            r1_neg <= r0_neg;
            r1_v   <= r0_v;
        end
    end

    // stage 2: B - C*x^2
    logic [15:0]                  r2_x [NL];
    logic [15:0]                  r2_x2 [NL];
    logic [14:0]                  r2_t1 [NL];
    logic [NL-1:0]                r2_neg;
    logic signed [COORD_BITS-1:0] r2_v [3];
    logic [27:0]                  pc [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            pc[l] = erpv_pkg::SIN_C * r1_x2[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int l = 0; l < NL; l++) begin
                r2_x[l]  <= r1_x[l];
                r2_x2[l] <= r1_x2[l];
                r2_t1[l] <= erpv_pkg::SIN_B - {3'b0, pc[l][26:15]};
            end
            r2_neg <= r1_neg;
            r2_v   <= r1_v;
        end
    end

    // stage 3: A - x^2*(...)
    logic [15:0]                  r3_x [NL];
    logic [15:0]                  r3_t3 [NL];
    logic [NL-1:0]                r3_neg;
    logic signed [COORD_BITS-1:0] r3_v [3];
    logic [30:0]                  pt [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            pt[l] = r2_t1[l] * r2_x2[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int l = 0; l < NL; l++) begin
                r3_x[l]  <= r2_x[l];
                r3_t3[l] <= erpv_pkg::SIN_A - {1'b0, pt[l][29:15]};
            end
            r3_neg <= r2_neg;
            r3_v   <= r2_v;
        end
    end

    // stage 4: signed Q14 sine
    logic signed [16:0]           r4_s [NL];
    logic signed [COORD_BITS-1:0] r4_v [3];
    logic [31:0]                  ps [NL];
    logic signed [16:0]           mag [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            ps[l]  = r3_t3[l] * r3_x[l];
            mag[l] = $signed({1'b0, ps[l][31:16]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int l = 0; l < NL; l++) begin
                r4_s[l] <= r3_neg[l] ? -mag[l] : mag[l];
            end
            r4_v <= r3_v;
        end
    end

    // stage 5: pairwise matrix products
    logic signed [16:0] r5_cysp, r5_sysp, r5_m00, r5_m10, r5_m21, r5_m22;
    logic signed [16:0] r5_sr, r5_cr, r5_sp, r5_sy, r5_cy;
    logic signed [COORD_BITS-1:0] r5_v [3];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_cysp <= qmul(r4_s[5], r4_s[2]);
            r5_sysp <= qmul(r4_s[4], r4_s[2]);
            r5_m00  <= qmul(r4_s[5], r4_s[3]);
            r5_m10  <= qmul(r4_s[4], r4_s[3]);
            r5_m21  <= qmul(r4_s[3], r4_s[0]);
            r5_m22  <= qmul(r4_s[3], r4_s[1]);
            r5_sr   <= r4_s[0];
            r5_cr   <= r4_s[1];
            r5_sp   <= r4_s[2];
            r5_sy   <= r4_s[4];
            r5_cy   <= r4_s[5];
            r5_v    <= r4_v;
        end
    end

    // stage 6: matrix entries
    logic signed [MW-1:0]         r6_m [9];
    logic signed [COORD_BITS-1:0] r6_v [3];

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_m[0] <= MW'(r5_m00);
            r6_m[1] <= MW'(qmul(r5_cysp, r5_sr)) - MW'(qmul(r5_sy, r5_cr));
            r6_m[2] <= MW'(qmul(r5_cysp, r5_cr)) + MW'(qmul(r5_sy, r5_sr));
            r6_m[3] <= MW'(r5_m10);
            r6_m[4] <= MW'(qmul(r5_sysp, r5_sr)) + MW'(qmul(r5_cy, r5_cr));
            r6_m[5] <= MW'(qmul(r5_sysp, r5_cr)) - MW'(qmul(r5_cy, r5_sr));
            r6_m[6] <= -MW'(r5_sp);
            r6_m[7] <= MW'(r5_m21);
            r6_m[8] <= MW'(r5_m22);
            r6_v    <= r5_v;
        end
    end

    // stage 7: vertex products
    logic signed [PW-1:0] r7_p [9];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            for (int i = 0; i < 9; i++) begin
                r7_p[i] <= PW'(r6_m[i]) * PW'(r6_v[i%3]);
            end
        end
    end

    // stage 8: row sums rounded to Q8.8
    logic signed [RB-1:0] r8_r [3];
    logic signed [SW-1:0] rsum [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rsum[c] = SW'(r7_p[3*c]) + SW'(r7_p[3*c+1]) + SW'(r7_p[3*c+2])
                      + SW'(8192);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            for (int c = 0; c < 3; c++) begin
                r8_r[c] <= rsum[c][RB+13:14];
            end
        end
    end

    // stage 9: depth, visibility, saturated z, scaled x/y
    logic signed [DW-1:0]         r9_depth;
    logic                         r9_front;
    logic [COORD_BITS-1:0]        r9_rzs;
    logic signed [RB+7:0]         r9_rx100, r9_ry100;
    logic signed [DW-1:0]         depth;

    assign depth = DW'($signed({1'b0, r_view_dist})) + DW'(r8_r[2]);

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r9_depth <= depth;
            r9_front <= depth > DW'(erpv_pkg::NEAR_Q88);
            if (r8_r[2] > Z_HI) begin
                r9_rzs <= Z_HI[COORD_BITS-1:0];
            end else if (r8_r[2] < Z_LO) begin
                r9_rzs <= Z_LO[COORD_BITS-1:0];
            end else begin
                r9_rzs <= r8_r[2][COORD_BITS-1:0];
            end
            r9_rx100 <= (RB+8)'(r8_r[0]) * (RB+8)'(erpv_pkg::FOCAL);
            r9_ry100 <= (RB+8)'(r8_r[1]) * (RB+8)'(erpv_pkg::FOCAL);
        end
    end

    // stage 10: center times depth
    logic signed [DW+10:0]  r10_cxd, r10_cyd;
    logic signed [RB+7:0]   r10_rx100, r10_ry100;
    logic signed [DW-1:0]   r10_depth;
    logic                   r10_front;
    logic [COORD_BITS-1:0]  r10_rzs;

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r10_cxd   <= (DW+11)'($signed({1'b0, r_center_x})) * (DW+11)'(r9_depth);
            r10_cyd   <= (DW+11)'($signed({1'b0, r_center_y})) * (DW+11)'(r9_depth);
            r10_rx100 <= r9_rx100;
            r10_ry100 <= r9_ry100;
            r10_depth <= r9_depth;
            r10_front <= r9_front;
            r10_rzs   <= r9_rzs;
        end
    end

    // stage 11: numerators
    logic signed [NW-1:0]   r11_nx, r11_ny;
    logic signed [DW-1:0]   r11_depth;
    logic                   r11_front;
    logic [COORD_BITS-1:0]  r11_rzs;

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            r11_nx    <= NW'(r10_cxd) + NW'(r10_rx100);
            r11_ny    <= NW'(r10_cyd) - NW'(r10_ry100);
            r11_depth <= r10_depth;
            r11_front <= r10_front;
            r11_rzs   <= r10_rzs;
        end
    end

    // stage 12: sign and magnitude
    logic [NW-1:0]          r12_a [2];
    logic [1:0]             r12_neg;
    logic [RB-1:0]          r12_dmag;
    logic                   r12_front;
    logic [COORD_BITS-1:0]  r12_rzs;

    always_ff @(posedge i_clk) begin
        if (en[12]) begin
            r12_a[0]  <= r11_nx[NW-1] ? NW'(-r11_nx) : NW'(r11_nx);
            r12_a[1]  <= r11_ny[NW-1] ? NW'(-r11_ny) : NW'(r11_ny);
            r12_neg   <= {r11_ny[NW-1], r11_nx[NW-1]};
            r12_dmag  <= r11_depth[RB-1:0];
            r12_front <= r11_front;
            r12_rzs   <= r11_rzs;
        end
    end

    // stages 13..25: restoring divider, one quotient bit per stage
    logic [NW-1:0]          r_dv_rem [QB][2];
    logic [QB-1:0]          r_dv_q   [QB][2];
    logic [1:0]             r_dv_neg [QB];
    logic [RB-1:0]          r_dv_dmag [QB];
    logic                   r_dv_front [QB];
    logic [COORD_BITS-1:0]  r_dv_rzs [QB];

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int B = QB - 1 - k;
        logic [NW-1:0]         rem_in [2];
        logic [QB-1:0]         q_in [2];
        logic [RB-1:0]         dmag_in;
        logic [1:0]            neg_in;
        logic                  front_in;
        logic [COORD_BITS-1:0] rzs_in;
        logic [NW-1:0]         sub;

        if (k == 0) begin : g_first
            always_comb begin
                rem_in   = r12_a;
                q_in[0]  = '0;
                q_in[1]  = '0;
                dmag_in  = r12_dmag;
                neg_in   = r12_neg;
                front_in = r12_front;
                rzs_in   = r12_rzs;
            end
        end else begin : g_next
            always_comb begin
                rem_in   = r_dv_rem[k-1];
                q_in     = r_dv_q[k-1];
                dmag_in  = r_dv_dmag[k-1];
                neg_in   = r_dv_neg[k-1];
                front_in = r_dv_front[k-1];
                rzs_in   = r_dv_rzs[k-1];
            end
        end

        assign sub = NW'(dmag_in) << B;

        always_ff @(posedge i_clk) begin
            if (en[ST_DIV0+k]) begin
                for (int a = 0; a < 2; a++) begin
                    if (rem_in[a] >= sub) begin
                        r_dv_rem[k][a] <= rem_in[a] - sub;
                        r_dv_q[k][a]   <= q_in[a] | (QB'(1) << B);
                    end else begin
                        r_dv_rem[k][a] <= rem_in[a];
                        r_dv_q[k][a]   <= q_in[a];
                    end
                end
                r_dv_dmag[k]  <= dmag_in;
                r_dv_neg[k]   <= neg_in;
                r_dv_front[k] <= front_in;
                r_dv_rzs[k]   <= rzs_in;
            end
        end
    end

    // output stage: saturate and select
    erpv_pkg::t_out_item r_out;
    logic signed [11:0]  scr [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (!r_dv_neg[QB-1][a]) begin
                scr[a] = (r_dv_q[QB-1][a] > QB'(2047)) ? erpv_pkg::SCREEN_HI
                                                       : r_dv_q[QB-1][a][11:0];
            end else begin
                scr[a] = (r_dv_q[QB-1][a] > QB'(2048)) ? erpv_pkg::SCREEN_LO
                                                       : -r_dv_q[QB-1][a][11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out.screen_x  <= r_dv_front[QB-1] ? scr[0] : {2'b0, r_center_x};
            r_out.screen_y  <= r_dv_front[QB-1] ? scr[1] : {2'b0, r_center_y};
            r_out.rotated_z <= 16'(r_dv_rzs[QB-1]);
            r_out.in_front  <= r_dv_front[QB-1];
        end
    end

    assign o_pix.valid = r_vld[ST_OUT];
    assign o_pix.data  = r_out;

    // checks
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("result valid right after reset");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pix.valid |-> i_vtx.ready)
        else $error("input stalled with empty output stage");

    a_behind_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && !o_pix.data.in_front |->
            o_pix.data.screen_x == $signed({2'b0, r_center_x}) &&
            o_pix.data.screen_y == $signed({2'b0, r_center_y}))
        else $error("point behind camera not on screen center");

endmodule
